[rtl/rcpdm_pkg.sv]
`timescale 1ns / 1ps

package rcpdm_pkg;

  localparam int PULSE_W        = 16;
  localparam int DB_W           = 7;
  localparam int LEVEL_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int TIMER_BITS_DEF = 16;

  localparam int AMP_SH   = 7;                   // gain of 128
  localparam int DIVD_W   = PULSE_W + AMP_SH;    // 128 * width
  localparam int GAIN_W   = 15;                  // gain never exceeds 16448
  localparam int RAW_W    = DIVD_W + 2;
  localparam int SCALED_W = 9;
  localparam int DRIVE_W  = 10;
  localparam int DUTY_W   = 8;
  localparam int MAG_W    = 8;
  localparam int ROT_W    = 7;

  localparam int OUT_MAX   = 255;
  localparam int SPAN      = 2 * OUT_MAX;
  localparam int DRIVE_PCT = 98;
  localparam int DRIVE_MAX = (DRIVE_PCT * OUT_MAX) / 100;
  localparam int TRACK     = 100;

  localparam logic signed [SCALED_W-1:0] SCALED_HI = SCALED_W'(OUT_MAX);
  localparam logic signed [SCALED_W-1:0] SCALED_LO = -SCALED_W'(OUT_MAX);
  localparam logic signed [RAW_W-1:0]    RAW_HI    = RAW_W'(OUT_MAX);
  localparam logic signed [RAW_W-1:0]    RAW_LO    = -RAW_W'(OUT_MAX);
  localparam logic signed [DRIVE_W-1:0]  DRV_HI    = DRIVE_W'(DRIVE_MAX);
  localparam logic signed [DRIVE_W-1:0]  DRV_LO    = -DRIVE_W'(DRIVE_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_MIN   = 2'd0,
    CFG_PULSE_MAX   = 2'd1,
    CFG_DEAD_BAND   = 2'd2,
    CFG_PIVOT_LEVEL = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_RISE  = 2'd0,
    PH_FALL  = 2'd1,
    PH_STEER = 2'd2
  } edge_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_GAIN_WAIT,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_RAW,
    ST_PICK,
    ST_MIX,
    ST_MIX_WAIT,
    ST_OUT
  } top_state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] port_duty;
    logic              port_reverse;
    logic [DUTY_W-1:0] starboard_duty;
    logic              starboard_reverse;
    logic              relay_closed;
  } mix_res_t;

  // floor(x / 255), exact for x below 65280
  function automatic logic [15:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = 17'(x) + 17'(x >> 8) + 17'd1;
    return acc[16:1] >> 7;
  endfunction

  function automatic logic signed [SCALED_W-1:0] scale_pick(
    input logic                    lost,
    input logic                    above,
    input logic                    below,
    input logic                    gain_zero,
    input logic signed [RAW_W-1:0] raw,
    input logic [DB_W-1:0]         db
  );
    logic signed [SCALED_W-1:0] s;
    logic        [SCALED_W-1:0] m;
    if (raw > RAW_HI) begin
      s = SCALED_HI;
    end else if (raw < RAW_LO) begin
      s = SCALED_LO;
    end else begin
      s = raw[SCALED_W-1:0];
    end
    m = s[SCALED_W-1] ? SCALED_W'(-s) : SCALED_W'(s);
    if (lost) return '0;
    if (above) return SCALED_HI;
    if (below) return SCALED_LO;
    if (gain_zero) return '0;
    return (m > SCALED_W'(db)) ? s : '0;
  endfunction

  function automatic logic signed [SCALED_W-1:0] clamp_drive(
    input logic signed [DRIVE_W-1:0] v
  );
    if (v > DRV_HI) return SCALED_W'(DRV_HI);
    if (v < DRV_LO) return SCALED_W'(DRV_LO);
    return v[SCALED_W-1:0];
  endfunction

endpackage

[rtl/rcpdm_div.sv]
`timescale 1ns / 1ps

module rcpdm_div
  import rcpdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [GAIN_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [GAIN_W-1:0] rem;
  logic [GAIN_W-1:0] dvs;
  logic [DIVD_W-1:0] quo;

  logic [GAIN_W:0]   rem_sh;
  logic [GAIN_W:0]   rem_sub;
  logic              qbit;
  logic [GAIN_W-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, quo[DIVD_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs};
    qbit     = (rem_sh >= {1'b0, dvs});
    rem_next = qbit ? rem_sub[GAIN_W-1:0] : rem_sh[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
      cnt <= CNT_W'(DIVD_W - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVD_W-2:0], qbit};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

[rtl/rcpdm_mix.sv]
`timescale 1ns / 1ps

module rcpdm_mix
  import rcpdm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SCALED_W-1:0] thrust,
  input  logic signed [SCALED_W-1:0] steer,
  input  logic [LEVEL_W-1:0]         level,
  output logic                       done,
  output mix_res_t                   res
);

  logic [4:0] vs;

  logic signed [SCALED_W-1:0] thr_r;
  logic signed [SCALED_W-1:0] str_r;
  logic              tneg;
  logic              sneg;
  logic [MAG_W-1:0]  tmag;
  logic [MAG_W-1:0]  smag;
  logic [MAG_W-1:0]  xmag;
  logic [MAG_W-1:0]  dmag;
  logic              dneg;
  logic [MAG_W-1:0]  ymag;
  logic [ROT_W-1:0]  rmag;
  logic              pivot_lock;

  logic [MAG_W-1:0]  in_tmag;
  logic [MAG_W-1:0]  in_smag;
  logic [15:0]       xq;
  logic [15:0]       dprod;
  logic [15:0]       yq;
  logic [13:0]       rprod;

  logic signed [SCALED_W-1:0] rot;
  logic signed [SCALED_W-1:0] port_v;
  logic signed [SCALED_W-1:0] stbd_v;
  logic                       use_mix;
  logic [SCALED_W-1:0]        port_m;
  logic [SCALED_W-1:0]        stbd_m;

  always_comb begin
    in_tmag = thrust[SCALED_W-1] ? MAG_W'(-thrust) : MAG_W'(thrust);
    in_smag = steer[SCALED_W-1] ? MAG_W'(-steer) : MAG_W'(steer);
    xq      = div255(16'({in_smag, {AMP_SH{1'b0}}}));
    dprod   = 16'(tmag) * 16'(xmag);
    yq      = div255(16'({dmag, {AMP_SH{1'b0}}}));
    rprod   = 14'(ymag) * 14'(TRACK);
  end

  always_comb begin
    rot     = dneg ? -SCALED_W'(rmag) : SCALED_W'(rmag);
    use_mix = (thr_r != '0) && !pivot_lock;
    if (use_mix) begin
      port_v = clamp_drive(DRIVE_W'(thr_r) - DRIVE_W'(rot));
      stbd_v = clamp_drive(DRIVE_W'(thr_r) + DRIVE_W'(rot));
    end else begin
      port_v = clamp_drive(DRIVE_W'(str_r));
      stbd_v = clamp_drive(-DRIVE_W'(str_r));
    end
    port_m = port_v[SCALED_W-1] ? SCALED_W'(-port_v) : SCALED_W'(port_v);
    stbd_m = stbd_v[SCALED_W-1] ? SCALED_W'(-stbd_v) : SCALED_W'(stbd_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs         <= '0;
      pivot_lock <= 1'b0;
    end else begin
      vs <= {vs[3:0], start};
      if (vs[3] && !use_mix) begin
        pivot_lock <= (smag > level);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      thr_r <= thrust;
      str_r <= steer;
      tneg  <= thrust[SCALED_W-1];
      sneg  <= steer[SCALED_W-1];
      tmag  <= in_tmag;
      smag  <= in_smag;
      xmag  <= xq[MAG_W-1:0];
    end
    if (vs[0]) begin
      dmag <= dprod[AMP_SH +: MAG_W];
      dneg <= tneg ^ sneg;
    end
    if (vs[1]) begin
      ymag <= yq[MAG_W-1:0];
    end
    if (vs[2]) begin
      rmag <= rprod[AMP_SH +: ROT_W];
    end
    if (vs[3]) begin
      res.port_duty         <= port_m[DUTY_W-1:0];
      res.port_reverse      <= port_v[SCALED_W-1];
      res.starboard_duty    <= stbd_m[DUTY_W-1:0];
      res.starboard_reverse <= stbd_v[SCALED_W-1];
      res.relay_closed      <= (port_v != '0) || (stbd_v != '0);
    end
  end

  assign done = vs[4];

endmodule

[rtl/rc_pulse_differential_drive_mixer.sv]
`timescale 1ns / 1ps

// RC pulse differential drive mixer.
// Input channel (in_valid/in_ready): one item per capture event, op 0 for a
// timer edge with its timestamp, op 1 for a watchdog timeout. Edges run in
// frames of thrust rise, thrust fall, steer fall.
// Output channel (out_valid/out_ready): exactly one item per input item with
// port and starboard duty and direction, relay, idle lamp and signal lost.
// Config port (cfg_we/cfg_index/cfg_data): pulse_min, pulse_max, dead_band,
// pivot_lock_level. The user is bound to write them only while no item is in
// flight; the block itself does not enforce it.
// One item is in work at a time: no new item is accepted until the last one
// has loaded the output register. Its work is two passes of the bit-serial
// dividers (the gain, then three quotients in parallel lanes), then the
// ST_RAW and ST_PICK states to pick the scaled values, the five-stage mixer
// and ST_OUT to load the output register.
// The result sits in an output register, so the next item is accepted while
// a stalled result waits; the block stops only at the end of that next item.
// Reset restores the register defaults, restarts the frame and marks the
// signal lost; the pivot lock is released.

module rc_pulse_differential_drive_mixer
  import rcpdm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [PULSE_W-1:0]   timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    port_duty,
  output logic                 port_reverse,
  output logic [DUTY_W-1:0]    starboard_duty,
  output logic                 starboard_reverse,
  output logic                 relay_closed,
  output logic                 idle_lamp,
  output logic                 signal_lost
);

  localparam int CMP_W = (TIMER_BITS > PULSE_W) ? TIMER_BITS : PULSE_W;

  logic [PULSE_W-1:0] pulse_min;
  logic [PULSE_W-1:0] pulse_max;
  logic [DB_W-1:0]    dead_band;
  logic [LEVEL_W-1:0] pivot_level;

  top_state_t  state;
  top_state_t  state_next;
  edge_phase_t edge_phase;

  logic [TIMER_BITS-1:0] rise_time;
  logic [TIMER_BITS-1:0] fall_time;
  logic [TIMER_BITS-1:0] thrust_width;
  logic [TIMER_BITS-1:0] steer_width;
  logic [TIMER_BITS-1:0] ts;
  logic                  lost;

  logic [GAIN_W-1:0]           gain;
  logic signed [RAW_W-1:0]     raw_thr;
  logic signed [RAW_W-1:0]     raw_str;
  logic                        thr_above, thr_below, str_above, str_below;
  logic signed [SCALED_W-1:0]  thrust;
  logic signed [SCALED_W-1:0]  steer;

  logic              accept;
  logic              div_start0;
  logic              div_start12;
  logic              mix_start;
  logic              out_load;
  logic [PULSE_W-1:0] span_diff;
  logic [DIVD_W-1:0] dvd0;
  logic [GAIN_W-1:0] dvs0;
  logic [DIVD_W-1:0] q_thr, q_str, q_min;
  logic              done_thr, done_str, done_min;
  logic              mix_done;
  mix_res_t          mix_res;

  assign accept    = in_valid && in_ready;
  assign ts        = TIMER_BITS'(timestamp);
  assign span_diff = pulse_max - pulse_min;
  assign dvd0      = (state == ST_GAIN) ? {span_diff, {AMP_SH{1'b0}}}
                                        : {PULSE_W'(thrust_width), {AMP_SH{1'b0}}};
  assign dvs0      = (state == ST_GAIN) ? GAIN_W'(SPAN) : gain;

  rcpdm_div u_div_thr (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start0),
    .dividend (dvd0),
    .divisor  (dvs0),
    .done     (done_thr),
    .quotient (q_thr)
  );

  rcpdm_div u_div_str (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start12),
    .dividend ({PULSE_W'(steer_width), {AMP_SH{1'b0}}}),
    .divisor  (gain),
    .done     (done_str),
    .quotient (q_str)
  );

  rcpdm_div u_div_min (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start12),
    .dividend ({pulse_min, {AMP_SH{1'b0}}}),
    .divisor  (gain),
    .done     (done_min),
    .quotient (q_min)
  );

  rcpdm_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (mix_start),
    .thrust (thrust),
    .steer  (steer),
    .level  (pivot_level),
    .done   (mix_done),
    .res    (mix_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    div_start0  = 1'b0;
    div_start12 = 1'b0;
    mix_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        div_start0 = 1'b1;
        state_next = ST_GAIN_WAIT;
      end
      ST_GAIN_WAIT: begin
        if (done_thr) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        div_start0  = 1'b1;
        div_start12 = 1'b1;
        state_next  = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (done_thr) state_next = ST_RAW;
      end
      ST_RAW: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        state_next = ST_MIX;
      end
      ST_MIX: begin
        mix_start  = 1'b1;
        state_next = ST_MIX_WAIT;
      end
      ST_MIX_WAIT: begin
        if (mix_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // config registers and frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min    <= PULSE_W'(14970);
      pulse_max    <= PULSE_W'(27530);
      dead_band    <= DB_W'(10);
      pivot_level  <= LEVEL_W'(15);
      edge_phase   <= PH_RISE;
      rise_time    <= '0;
      fall_time    <= '0;
      thrust_width <= '0;
      steer_width  <= '0;
      lost         <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PULSE_MIN:   pulse_min   <= cfg_data;
          CFG_PULSE_MAX:   pulse_max   <= cfg_data;
          CFG_DEAD_BAND:   dead_band   <= cfg_data[DB_W-1:0];
          CFG_PIVOT_LEVEL: pivot_level <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (op) begin
          lost       <= 1'b1;
          edge_phase <= PH_RISE;
        end else begin
          case (edge_phase)
            PH_FALL: begin
              fall_time    <= ts;
              thrust_width <= ts - rise_time;
              edge_phase   <= PH_STEER;
            end
            PH_STEER: begin
              steer_width <= ts - fall_time;
              edge_phase  <= PH_RISE;
              lost        <= 1'b0;
            end
            default: begin
              rise_time  <= ts;
              edge_phase <= PH_FALL;
            end
          endcase
        end
      end
    end
  end

  // scaling datapath
  always_ff @(posedge clk) begin
    if (state == ST_GAIN_WAIT && done_thr) begin
      gain <= q_thr[GAIN_W-1:0];
    end
    if (state == ST_RAW) begin
      raw_thr   <= RAW_W'(q_thr) - RAW_W'(q_min) - RAW_W'(OUT_MAX);
      raw_str   <= RAW_W'(q_str) - RAW_W'(q_min) - RAW_W'(OUT_MAX);
      thr_above <= CMP_W'(thrust_width) > CMP_W'(pulse_max);
      thr_below <= CMP_W'(thrust_width) < CMP_W'(pulse_min);
      str_above <= CMP_W'(steer_width) > CMP_W'(pulse_max);
      str_below <= CMP_W'(steer_width) < CMP_W'(pulse_min);
    end
    if (state == ST_PICK) begin
      thrust <= scale_pick(lost, thr_above, thr_below, gain == '0, raw_thr, dead_band);
      steer  <= scale_pick(lost, str_above, str_below, gain == '0, raw_str, dead_band);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      port_duty         <= mix_res.port_duty;
      port_reverse      <= mix_res.port_reverse;
      starboard_duty    <= mix_res.starboard_duty;
      starboard_reverse <= mix_res.starboard_reverse;
      relay_closed      <= mix_res.relay_closed;
      idle_lamp         <= !mix_res.relay_closed;
      signal_lost       <= lost;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_GAIN)
    else $error("accepted item did not start the gain pass");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (done_str == done_min) && (!done_str || done_thr))
    else $error("divider lanes out of step");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    done_thr |-> (state == ST_GAIN_WAIT || state == ST_SCALE_WAIT))
    else $error("divider finished outside a wait state");

  a_mix_done_wait: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> state == ST_MIX_WAIT)
    else $error("mixer finished outside its wait state");

  a_lamp_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_closed != idle_lamp) &&
                  (relay_closed == (port_duty != '0 || starboard_duty != '0)))
    else $error("relay and lamp disagree with the drives");

endmodule

[sim/rc_pulse_differential_drive_mixer_tb.sv]
`timescale 1ns / 1ps

module rc_pulse_differential_drive_mixer_tb;
  import rcpdm_pkg::*;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;
  localparam int   FULL_SCALE = 255;
  localparam int   DRIVE_CAP  = 249;
  localparam int   PHASE_ITEMS = 150;
  localparam int   NUM_PHASES  = 8;

  typedef struct packed {
    logic [7:0] port_duty;
    logic       port_reverse;
    logic [7:0] starboard_duty;
    logic       starboard_reverse;
    logic       relay_closed;
    logic       idle_lamp;
    logic       signal_lost;
  } drive_res_t;

  typedef struct packed {
    logic       is_cfg;
    cfg_reg_t   reg_sel;
    logic       op_bit;
    logic [15:0] value;
    logic       typed;
    drive_res_t want;
  } script_row_t;

  localparam drive_res_t LOST_IDLE = '{8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam drive_res_t FULL_TURN = '{8'd249, 1'b0, 8'd155, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam drive_res_t NO_RES    = '0;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PULSE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [PULSE_W-1:0] timestamp = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] port_duty;
  logic port_reverse;
  logic [DUTY_W-1:0] starboard_duty;
  logic starboard_reverse;
  logic relay_closed;
  logic idle_lamp;
  logic signal_lost;

  rc_pulse_differential_drive_mixer u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .timestamp         (timestamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .port_duty         (port_duty),
    .port_reverse      (port_reverse),
    .starboard_duty    (starboard_duty),
    .starboard_reverse (starboard_reverse),
    .relay_closed      (relay_closed),
    .idle_lamp         (idle_lamp),
    .signal_lost       (signal_lost)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state and register copies
  edge_phase_t fr_phase;
  logic [15:0] rise_ts, fall_ts, thrust_w, steer_w;
  logic        lost_q, pivot_q;
  logic [15:0] p_min, p_max;
  logic [6:0]  db_lvl;
  logic [7:0]  pivot_lvl;

  drive_res_t  drives_due[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          events_sent = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  function automatic int clip_drive(input int v);
    if (v > DRIVE_CAP) return DRIVE_CAP;
    if (v < -DRIVE_CAP) return -DRIVE_CAP;
    return v;
  endfunction

  function automatic int scale_pulse(input logic [15:0] w);
    longint gain, s;
    if (lost_q) return 0;
    if (w > p_max) return FULL_SCALE;
    if (w < p_min) return -FULL_SCALE;
    gain = (128 * (longint'(p_max) - longint'(p_min))) / (2 * FULL_SCALE);
    if (gain <= 0) return 0;
    s = (128 * longint'(w)) / gain - ((128 * longint'(p_min)) / gain + FULL_SCALE);
    if (s > FULL_SCALE) s = FULL_SCALE;
    else if (s < -FULL_SCALE) s = -FULL_SCALE;
    return ((s < 0 ? -s : s) > longint'(db_lvl)) ? int'(s) : 0;
  endfunction

  function automatic drive_res_t predict_drive(input logic op_i, input logic [15:0] ts);
    int thrust, steer, diff, rot, port, stbd;
    drive_res_t r;
    if (op_i == OP_TIMEOUT) begin
      lost_q = 1'b1;
      fr_phase = PH_RISE;
    end else begin
      case (fr_phase)
        PH_FALL: begin
          fall_ts = ts;
          thrust_w = fall_ts - rise_ts;
          fr_phase = PH_STEER;
        end
        PH_STEER: begin
          steer_w = ts - fall_ts;
          fr_phase = PH_RISE;
          lost_q = 1'b0;
        end
        default: begin
          rise_ts = ts;
          fr_phase = PH_FALL;
        end
      endcase
    end
    steer = scale_pulse(steer_w);
    thrust = scale_pulse(thrust_w);
    diff = (thrust * ((128 * steer) / FULL_SCALE)) / 128;
    rot = (100 * ((128 * diff) / FULL_SCALE)) / 128;
    if (thrust != 0 && !pivot_q) begin
      port = clip_drive(thrust - rot);
      stbd = clip_drive(thrust + rot);
    end else begin
      pivot_q = ((steer < 0) ? -steer : steer) > int'(pivot_lvl);
      port = clip_drive(steer);
      stbd = clip_drive(-steer);
    end
    r.port_duty = 8'((port < 0) ? -port : port);
    r.port_reverse = (port < 0);
    r.starboard_duty = 8'((stbd < 0) ? -stbd : stbd);
    r.starboard_reverse = (stbd < 0);
    r.relay_closed = (port != 0 || stbd != 0);
    r.idle_lamp = (port == 0 && stbd == 0);
    r.signal_lost = lost_q;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [15:0] pick_width();
    int lo, hi, m, c;
    if (p_min > p_max || $urandom_range(0, 7) == 0) return 16'($urandom);
    m = (int'(p_max) - int'(p_min)) / 8 + 4;
    if ($urandom_range(0, 4) == 0) begin
      // near center: zero thrust, dead band, pivot
      c = (int'(p_min) + int'(p_max)) / 2;
      lo = c - m / 4;
      hi = c + m / 4;
    end else begin
      lo = int'(p_min) - m;
      hi = int'(p_max) + m;
    end
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic void add_event(input logic op_i, input logic [15:0] ts,
                                    input logic typed, input drive_res_t want);
    script.push_back('{1'b0, CFG_PULSE_MIN, op_i, ts, typed, want});
  endfunction

  function automatic void add_write(input cfg_reg_t idx, input logic [15:0] val);
    script.push_back('{1'b1, idx, OP_EDGE, val, 1'b0, NO_RES});
  endfunction

  function automatic void add_frame(input logic [15:0] t, input logic [15:0] wt,
                                    input logic [15:0] ws);
    add_event(OP_EDGE, t, 1'b0, NO_RES);
    add_event(OP_EDGE, t + wt, 1'b0, NO_RES);
    add_event(OP_EDGE, t + wt + ws, 1'b0, NO_RES);
  endfunction

  task automatic push_event(input logic op_i, input logic [15:0] ts,
                            input logic typed, input drive_res_t want);
    int gap;
    drive_res_t predicted;
    gap = pick_gap();
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_i;
    timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_drive(op_i, ts);
    drives_due.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_PULSE_MIN: p_min = val;
      CFG_PULSE_MAX: p_max = val;
      CFG_DEAD_BAND: db_lvl = val[6:0];
      default:       pivot_lvl = val[7:0];
    endcase
  endtask

  task automatic check_drive(input drive_res_t want, input drive_res_t got);
    if (got.port_duty !== want.port_duty) begin
      $error("port_duty: expected %0d, got %0d", want.port_duty, got.port_duty);
      mismatches++;
    end
    if (got.port_reverse !== want.port_reverse) begin
      $error("port_reverse: expected %0d, got %0d", want.port_reverse, got.port_reverse);
      mismatches++;
    end
    if (got.starboard_duty !== want.starboard_duty) begin
      $error("starboard_duty: expected %0d, got %0d", want.starboard_duty,
             got.starboard_duty);
      mismatches++;
    end
    if (got.starboard_reverse !== want.starboard_reverse) begin
      $error("starboard_reverse: expected %0d, got %0d", want.starboard_reverse,
             got.starboard_reverse);
      mismatches++;
    end
    if (got.relay_closed !== want.relay_closed) begin
      $error("relay_closed: expected %0d, got %0d", want.relay_closed, got.relay_closed);
      mismatches++;
    end
    if (got.idle_lamp !== want.idle_lamp) begin
      $error("idle_lamp: expected %0d, got %0d", want.idle_lamp, got.idle_lamp);
      mismatches++;
    end
    if (got.signal_lost !== want.signal_lost) begin
      $error("signal_lost: expected %0d, got %0d", want.signal_lost, got.signal_lost);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (drives_due.size() == 0) begin
        $error("result with no item pending");
        mismatches++;
      end else begin
        check_drive(drives_due.pop_front(),
                    '{port_duty, port_reverse, starboard_duty, starboard_reverse,
                      relay_closed, idle_lamp, signal_lost});
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    end
  end

  initial begin
    int a, b, c, d, pick, target;
    logic [15:0] t, wt, ws;

    fr_phase = PH_RISE;
    rise_ts = '0;
    fall_ts = '0;
    thrust_w = '0;
    steer_w = '0;
    lost_q = 1'b1;
    pivot_q = 1'b0;
    p_min = 16'd14970;
    p_max = 16'd27530;
    db_lvl = 7'd10;
    pivot_lvl = 8'd15;

    // reset values, timer wrap, full-scale frame, timeout
    add_event(OP_EDGE, 16'd0, 1'b1, LOST_IDLE);
    add_event(OP_EDGE, 16'hFFFF, 1'b1, LOST_IDLE);
    add_event(OP_EDGE, 16'd0, 1'b1, FULL_TURN);
    add_event(OP_TIMEOUT, 16'hFFFF, 1'b1, LOST_IDLE);
    add_frame(16'd100, 16'd27530, 16'd14970);
    // zero thrust, hard steer: pivot lock engages
    add_frame(16'd65000, 16'd21240, 16'd30000);
    // dead band edge on both signs, then just outside
    add_frame(16'd7, 16'd21480, 16'd20990);
    add_frame(16'd9, 16'd21510, 16'd20960);
    // min above max
    add_write(CFG_PULSE_MIN, 16'd30000);
    add_write(CFG_PULSE_MAX, 16'd100);
    add_frame(16'd0, 16'd20000, 16'd40000);
    // zero gain
    add_write(CFG_PULSE_MIN, 16'd20000);
    add_write(CFG_PULSE_MAX, 16'd20003);
    add_frame(16'd3, 16'd20001, 16'd20003);
    // coarse gain overshoots full scale
    add_write(CFG_PULSE_MAX, 16'd20004);
    add_frame(16'd5, 16'd20004, 16'd20000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        push_event(script[i].op_bit, script[i].value, script[i].typed, script[i].want);
      end
    end

    target = events_sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin a = 14970; b = 27530; c = 10; d = 15; end
        1: begin a = 0; b = 65535; c = 0; d = 0; end
        2: begin a = 65535; b = 0; c = 65535; d = 65535; end
        3: begin
          a = $urandom_range(0, 60000);
          b = a + $urandom_range(0, 12);
          c = $urandom;
          d = $urandom;
        end
        default: begin
          a = $urandom_range(0, 40000);
          b = a + $urandom_range(50, 25000);
          c = $urandom;
          d = $urandom;
        end
      endcase
      write_reg(CFG_PULSE_MIN, 16'(a));
      write_reg(CFG_PULSE_MAX, 16'(b));
      write_reg(CFG_DEAD_BAND, 16'(c));
      write_reg(CFG_PIVOT_LEVEL, 16'(d));
      quiet = (ph % 3 == 1);
      target += PHASE_ITEMS;
      while (events_sent < target) begin
        // realign to a frame start with stray edges
        while (fr_phase != PH_RISE) push_event(OP_EDGE, 16'($urandom), 1'b0, NO_RES);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          push_event(OP_TIMEOUT, 16'($urandom), 1'b0, NO_RES);
        end else if (pick == 1) begin
          push_event(OP_EDGE, 16'($urandom), 1'b0, NO_RES);
        end else begin
          t = 16'($urandom);
          wt = pick_width();
          ws = pick_width();
          push_event(OP_EDGE, t, 1'b0, NO_RES);
          if (pick == 2) begin
            push_event(OP_TIMEOUT, 16'($urandom), 1'b0, NO_RES);
          end else begin
            push_event(OP_EDGE, t + wt, 1'b0, NO_RES);
            push_event(OP_EDGE, t + wt + ws, 1'b0, NO_RES);
          end
        end
      end
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("rc_pulse_differential_drive_mixer_tb OK");
    end else begin
      $display("rc_pulse_differential_drive_mixer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("rc_pulse_differential_drive_mixer_tb NOT OK");
    $finish;
  end

endmodule
